FILE: rtl/core/afhc_pkg.sv
// ----------------------------------------------------------------------------
// afhc_pkg: shared types and constants of the autofocus hill climb controller
// Register codes, search phases, counter milestones and reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package afhc_pkg;

	// default payload widths
	localparam int Z_WIDTH_DEF     = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// configuration port
	localparam int CFG_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int STEP_WIDTH      = 31;
	localparam int LIMIT_WIDTH     = 32;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_INITIAL_STEP   = 2'd0,
		CFG_DEFOCUS_LIMIT  = 2'd1,
		CFG_FINE_THRESHOLD = 2'd2
	} cfg_index_t;

	localparam logic [STEP_WIDTH-1:0]         INITIAL_STEP_RST   = 31'd76800;
	localparam logic signed [LIMIT_WIDTH-1:0] DEFOCUS_LIMIT_RST  = 32'sd0;
	localparam logic [STEP_WIDTH-1:0]         FINE_THRESHOLD_RST = 31'd51200;

	// samples since restart, saturating
	localparam int COUNT_WIDTH = 4;
	localparam logic [COUNT_WIDTH-1:0] CNT_DEFOCUS = 4'd0;
	localparam logic [COUNT_WIDTH-1:0] CNT_LAST_UP = 4'd6;
	localparam logic [COUNT_WIDTH-1:0] CNT_PEAK    = 4'd7;
	localparam logic [COUNT_WIDTH-1:0] CNT_BACK    = 4'd8;
	localparam logic [COUNT_WIDTH-1:0] CNT_SAT     = 4'd10;

	// floor(x/3) = (x * RECIP) >> SHIFT for any x below 2^32
	localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;
	localparam int          DIV3_SHIFT = 33;

	typedef enum logic [1:0] {
		PH_COARSE     = 2'd0,
		PH_FIRST_FINE = 2'd1,
		PH_FINE       = 2'd2
	} phase_t;

	// decision of one coarse climb step on the sample window
	typedef struct packed {
		logic at_peak;    // middle Z at least as sharp as both others: go to midpoint
		logic move_down;  // highest Z not sharper than lowest: step back
	} climb_t;

endpackage

`default_nettype wire

FILE: rtl/core/afhc_if.sv
// ----------------------------------------------------------------------------
// afhc_if: handshake channels of the autofocus hill climb controller
// Sample channel (one focus measurement) and move channel (one stage order).
// ----------------------------------------------------------------------------
`default_nettype none

interface afhc_sample_if #(
	parameter int Z_WIDTH     = 32,
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic                          first;
	logic signed [Z_WIDTH-1:0]     z_position;
	logic        [VALUE_WIDTH-1:0] focus_value;

	modport source (output valid, first, z_position, focus_value, input ready);
	modport sink   (input valid, first, z_position, focus_value, output ready);
endinterface

interface afhc_move_if #(
	parameter int Z_WIDTH = 32
);
	logic                      valid;
	logic                      ready;
	logic                      move_absolute;
	logic signed [Z_WIDTH-1:0] move_amount;
	logic                      finished;

	modport source (output valid, move_absolute, move_amount, finished, input ready);
	modport sink   (input valid, move_absolute, move_amount, finished, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/afhc_climb.sv
// ----------------------------------------------------------------------------
// afhc_climb: coarse climb decision
// Sorts the three window samples by Z, then tells whether the middle one is
// the sharpest (with the floor midpoint of the two lowest Z) or which way
// to step.
// ----------------------------------------------------------------------------
`default_nettype none

module afhc_climb import afhc_pkg::*; #(
	parameter int Z_WIDTH     = Z_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic signed [Z_WIDTH-1:0]     z0,
	input  logic signed [Z_WIDTH-1:0]     z1,
	input  logic signed [Z_WIDTH-1:0]     z2,
	input  logic        [VALUE_WIDTH-1:0] v0,
	input  logic        [VALUE_WIDTH-1:0] v1,
	input  logic        [VALUE_WIDTH-1:0] v2,
	output climb_t                        decision,
	output logic signed [Z_WIDTH-1:0]     midpoint
);

	logic                          b_lp, b_lpp, b_ppp;
	logic [1:0]                    mn, md, mx;
	logic signed [Z_WIDTH-1:0]     z_mn, z_md;
	logic        [VALUE_WIDTH-1:0] v_mn, v_md, v_mx;
	logic signed [Z_WIDTH:0]       z_sum;

	// order the window by Z (index 2 newest, 0 oldest)
	always_comb begin
		b_lp  = z1 > z2;
		b_lpp = z0 > z2;
		b_ppp = z0 > z1;
		if (b_lp && b_lpp) begin
			mn = 2'd2;
			if (b_ppp) begin
				mx = 2'd0; md = 2'd1;
			end else begin
				mx = 2'd1; md = 2'd0;
			end
		end else if (b_ppp) begin
			mn = 2'd1;
			if (b_lpp) begin
				mx = 2'd0; md = 2'd2;
			end else begin
				mx = 2'd2; md = 2'd0;
			end
		end else begin
			mn = 2'd0;
			if (b_lp) begin
				mx = 2'd1; md = 2'd2;
			end else begin
				mx = 2'd2; md = 2'd1;
			end
		end
	end

	// pick the sorted samples
	always_comb begin
		case (mn)
			2'd0:    begin z_mn = z0; v_mn = v0; end
			2'd1:    begin z_mn = z1; v_mn = v1; end
			default: begin z_mn = z2; v_mn = v2; end
		endcase
		case (md)
			2'd0:    begin z_md = z0; v_md = v0; end
			2'd1:    begin z_md = z1; v_md = v1; end
			default: begin z_md = z2; v_md = v2; end
		endcase
		case (mx)
			2'd0:    v_mx = v0;
			2'd1:    v_mx = v1;
			default: v_mx = v2;
		endcase
	end

	// decide and form the floor midpoint
	always_comb begin
		decision.at_peak   = !(v_mn > v_md) && !(v_mx > v_md);
		decision.move_down = !(v_mx > v_mn);
		z_sum    = (Z_WIDTH+1)'(z_mn) + (Z_WIDTH+1)'(z_md);
		midpoint = z_sum[Z_WIDTH:1];
	end

endmodule

`default_nettype wire

FILE: rtl/core/autofocus_hill_climb_controller.sv
// ----------------------------------------------------------------------------
// autofocus_hill_climb_controller: hill climbing autofocus sequencer
// Takes one focus sample per word and answers one Z stage move order:
// coarse scan, climb on the last three samples, quarter-step fine scan.
//
//   channel  dir  handshake     word
//   sample   in   valid/ready   first, z_position, focus_value
//   move     out  valid/ready   move_absolute, move_amount, finished
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// One sample per cycle unless a move word stalls; it goes input register, then result register.
// The search state is updated in the same cycle the sample leaves the input
// register, so the next sample sees it at once.
// A stalled move word holds in the result register while one more sample
// waits in the input register; sample ready drops only then.
// arst_n clears the search state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module autofocus_hill_climb_controller import afhc_pkg::*; #(
	parameter int Z_WIDTH     = Z_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	afhc_sample_if.sink                sample,
	afhc_move_if.source                move
);

	// working width: holds Z, three steps and the limit with margin
	localparam int AW = ((Z_WIDTH > LIMIT_WIDTH) ? Z_WIDTH : LIMIT_WIDTH) + 4;

	// configuration registers
	logic        [STEP_WIDTH-1:0]  init_step_q;
	logic signed [LIMIT_WIDTH-1:0] defocus_q;
	logic        [STEP_WIDTH-1:0]  fine_thr_q;

	// input register
	logic                          valid_s1;
	logic                          first_s1;
	logic signed [Z_WIDTH-1:0]     z_s1;
	logic        [VALUE_WIDTH-1:0] value_s1;

	// result register
	logic                      valid_s2;
	logic                      abs_s2;
	logic signed [Z_WIDTH-1:0] amount_s2;
	logic                      fin_s2;

	// search state
	logic [COUNT_WIDTH-1:0]        count_q, count_nxt, count_eff;
	logic [STEP_WIDTH-1:0]         step_q, step_nxt, step_eff;
	phase_t                        phase_q, phase_nxt, phase_eff;
	logic signed [Z_WIDTH-1:0]     best_z_q, best_z_nxt, best_z_eff;
	logic [VALUE_WIDTH-1:0]        best_val_q, best_val_nxt, best_val_eff;
	logic signed [Z_WIDTH-1:0]     win_z_q [3];
	logic signed [Z_WIDTH-1:0]     win_z_nxt [3];
	logic signed [Z_WIDTH-1:0]     win_z_eff [3];
	logic [VALUE_WIDTH-1:0]        win_val_q [3];
	logic [VALUE_WIDTH-1:0]        win_val_nxt [3];
	logic [VALUE_WIDTH-1:0]        win_val_eff [3];
	logic                          done_q, done_nxt, done_eff;

	// datapath
	logic                          advance, take_s1;
	logic                          best_hit;
	logic signed [Z_WIDTH-1:0]     best_z_new;
	logic [VALUE_WIDTH-1:0]        best_val_new;
	logic signed [Z_WIDTH-1:0]     pw_z [3];
	logic [VALUE_WIDTH-1:0]        pw_val [3];
	logic [STEP_WIDTH+31:0]        div3_prod;
	logic [STEP_WIDTH-1:0]         step_div3;
	logic [STEP_WIDTH-1:0]         step_quarter;
	logic signed [AW-1:0]          z_w, st_w, st3_w, div3_w, quarter_w, limit_w, target_w;
	climb_t                        climb;
	logic signed [Z_WIDTH-1:0]     mid_z;
	logic                          res_abs, res_fin;
	logic signed [AW-1:0]          res_amount;
	logic signed [Z_WIDTH-1:0]     res_amount_sat;

	function automatic logic signed [Z_WIDTH-1:0] sat_z(input logic signed [AW-1:0] v);
		logic [AW-Z_WIDTH:0] hi;
		begin
			hi = v[AW-1:Z_WIDTH-1];
			if ((&hi) || !(|hi)) begin
				sat_z = v[Z_WIDTH-1:0];
			end else if (v[AW-1]) begin
				sat_z = {1'b1, {(Z_WIDTH-1){1'b0}}};
			end else begin
				sat_z = {1'b0, {(Z_WIDTH-1){1'b1}}};
			end
		end
	endfunction

	// handshake: move the input word on when the result register frees up
	assign advance      = !valid_s2 || move.ready;
	assign take_s1      = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_step_q <= INITIAL_STEP_RST;
			defocus_q   <= DEFOCUS_LIMIT_RST;
			fine_thr_q  <= FINE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_INITIAL_STEP:   init_step_q <= cfg_data[STEP_WIDTH-1:0];
				CFG_DEFOCUS_LIMIT:  defocus_q   <= signed'(cfg_data[LIMIT_WIDTH-1:0]);
				CFG_FINE_THRESHOLD: fine_thr_q  <= cfg_data[STEP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			first_s1 <= sample.first;
			z_s1     <= sample.z_position;
			value_s1 <= sample.focus_value;
		end
	end

	// restart view: a first sample sees cleared state and the initial step
	always_comb begin
		count_eff    = first_s1 ? '0 : count_q;
		step_eff     = first_s1 ? init_step_q : step_q;
		phase_eff    = first_s1 ? PH_COARSE : phase_q;
		best_z_eff   = first_s1 ? '0 : best_z_q;
		best_val_eff = first_s1 ? '0 : best_val_q;
		done_eff     = first_s1 ? 1'b0 : done_q;
		for (int i = 0; i < 3; i++) begin
			win_z_eff[i]   = first_s1 ? '0 : win_z_q[i];
			win_val_eff[i] = first_s1 ? '0 : win_val_q[i];
		end
	end

	// push the new sample, track the first maximum of the coarse scan
	always_comb begin
		pw_z[0]   = win_z_eff[1];
		pw_z[1]   = win_z_eff[2];
		pw_z[2]   = z_s1;
		pw_val[0] = win_val_eff[1];
		pw_val[1] = win_val_eff[2];
		pw_val[2] = value_s1;
		best_hit  = (count_eff <= CNT_PEAK) &&
			((count_eff == CNT_DEFOCUS) || (value_s1 > best_val_eff));
		best_z_new   = best_hit ? z_s1 : best_z_eff;
		best_val_new = best_hit ? value_s1 : best_val_eff;
	end

	// step arithmetic
	always_comb begin
		div3_prod    = (STEP_WIDTH+32)'(step_eff) * (STEP_WIDTH+32)'(DIV3_RECIP);
		step_div3    = STEP_WIDTH'(div3_prod >> DIV3_SHIFT);
		step_quarter = step_eff >> 2;
		z_w       = AW'(z_s1);
		st_w      = signed'(AW'(step_eff));
		st3_w     = st_w + (st_w <<< 1);
		div3_w    = signed'(AW'(step_div3));
		quarter_w = signed'(AW'(step_quarter));
		limit_w   = AW'(defocus_q);
		target_w  = z_w + st3_w;
	end

	afhc_climb #(
		.Z_WIDTH     (Z_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_climb (
		.z0       (pw_z[0]),
		.z1       (pw_z[1]),
		.z2       (pw_z[2]),
		.v0       (pw_val[0]),
		.v1       (pw_val[1]),
		.v2       (pw_val[2]),
		.decision (climb),
		.midpoint (mid_z)
	);

	// next search state
	always_comb begin
		count_nxt    = count_q;
		step_nxt     = step_q;
		phase_nxt    = phase_q;
		best_z_nxt   = best_z_q;
		best_val_nxt = best_val_q;
		done_nxt     = done_q;
		win_z_nxt    = win_z_q;
		win_val_nxt  = win_val_q;
		if (take_s1 && !done_eff) begin
			count_nxt    = (count_eff < CNT_SAT) ? count_eff + 1'b1 : count_eff;
			step_nxt     = step_eff;
			phase_nxt    = phase_eff;
			best_z_nxt   = best_z_new;
			best_val_nxt = best_val_new;
			done_nxt     = 1'b0;
			win_z_nxt    = pw_z;
			win_val_nxt  = pw_val;
			if (count_eff == CNT_PEAK) begin
				// the maximum joins the window as a pseudo sample
				win_z_nxt[0]   = pw_z[1];
				win_z_nxt[1]   = pw_z[2];
				win_z_nxt[2]   = best_z_new;
				win_val_nxt[0] = pw_val[1];
				win_val_nxt[1] = pw_val[2];
				win_val_nxt[2] = best_val_new;
				step_nxt       = step_div3;
			end else if (count_eff > CNT_BACK) begin
				if (phase_eff == PH_COARSE) begin
					if (climb.at_peak) begin
						if (step_eff < fine_thr_q) begin
							phase_nxt = PH_FIRST_FINE;
						end else begin
							step_nxt = step_div3;
						end
					end
				end else begin
					if (phase_eff != PH_FIRST_FINE && pw_val[2] < pw_val[1]) begin
						done_nxt = 1'b1;
					end
					phase_nxt = PH_FINE;
				end
			end
		end
	end

	// move order for this sample
	always_comb begin
		res_abs    = 1'b0;
		res_amount = '0;
		res_fin    = 1'b0;
		if (done_eff) begin
			res_fin = 1'b1;
		end else if (count_eff == CNT_DEFOCUS) begin
			if (target_w > limit_w) begin
				res_abs    = 1'b1;
				res_amount = limit_w;
			end else begin
				res_amount = st3_w;
			end
		end else if (count_eff <= CNT_LAST_UP) begin
			res_amount = -st_w;
		end else if (count_eff == CNT_PEAK) begin
			res_abs    = 1'b1;
			res_amount = AW'(best_z_new) + div3_w;
		end else if (count_eff == CNT_BACK) begin
			res_abs    = 1'b1;
			res_amount = z_w - (st_w <<< 1);
		end else if (phase_eff == PH_COARSE) begin
			if (climb.at_peak) begin
				res_abs    = 1'b1;
				res_amount = AW'(mid_z);
			end else if (climb.move_down) begin
				res_amount = -st_w;
			end else begin
				res_amount = st_w;
			end
		end else begin
			if (phase_eff != PH_FIRST_FINE && pw_val[2] < pw_val[1]) begin
				res_amount = -quarter_w;
				res_fin    = 1'b1;
			end else begin
				res_amount = quarter_w;
			end
		end
		res_amount_sat = sat_z(res_amount);
	end

	// hold the search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			step_q     <= '0;
			phase_q    <= PH_COARSE;
			best_z_q   <= '0;
			best_val_q <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				win_z_q[i]   <= '0;
				win_val_q[i] <= '0;
			end
		end else begin
			count_q    <= count_nxt;
			step_q     <= step_nxt;
			phase_q    <= phase_nxt;
			best_z_q   <= best_z_nxt;
			best_val_q <= best_val_nxt;
			done_q     <= done_nxt;
			win_z_q    <= win_z_nxt;
			win_val_q  <= win_val_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			abs_s2    <= res_abs;
			amount_s2 <= res_amount_sat;
			fin_s2    <= res_fin;
		end
	end

	assign move.valid         = valid_s2;
	assign move.move_absolute = abs_s2;
	assign move.move_amount   = amount_s2;
	assign move.finished      = fin_s2;

endmodule

`default_nettype wire

FILE: rtl/core/afhc_checker.sv
// ----------------------------------------------------------------------------
// afhc_checker: port-level checks of the autofocus hill climb controller
// Counts words in flight between the sample and move channels and checks
// the stall behavior seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module afhc_checker import afhc_pkg::*; #(
	parameter int Z_WIDTH = Z_WIDTH_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      sample_valid,
	input wire logic                      sample_ready,
	input wire logic                      move_valid,
	input wire logic                      move_ready,
	input wire logic                      move_absolute,
	input wire logic signed [Z_WIDTH-1:0] move_amount,
	input wire logic                      finished
);

	logic [1:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = sample_valid && sample_ready;
	assign out_acc = move_valid && move_ready;

	// count words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// a stalled move word holds
	a_move_hold: assert property (@(posedge clk) disable iff (!arst_n)
		move_valid && !move_ready |=> move_valid && $stable(move_amount) &&
			$stable(move_absolute) && $stable(finished))
		else $error("move word changed while stalled");

	// sample ready drops only behind a stalled move word
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> move_valid && !move_ready)
		else $error("sample channel blocked without a stalled move word");

	// at most two words inside the block
	a_inflight_max: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more words in flight than stages");

	// every move word answers a taken sample
	a_move_source: assert property (@(posedge clk) disable iff (!arst_n)
		move_valid |-> inflight_q != 2'd0)
		else $error("move word without a sample");

endmodule

bind autofocus_hill_climb_controller afhc_checker #(
	.Z_WIDTH (Z_WIDTH)
) u_afhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_valid  (sample.valid),
	.sample_ready  (sample.ready),
	.move_valid    (move.valid),
	.move_ready    (move.ready),
	.move_absolute (move.move_absolute),
	.move_amount   (move.move_amount),
	.finished      (move.finished)
);

`default_nettype wire
